>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the console writer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define TCW_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define TCW_ASSERT(lbl, prop)
`define TCW_NEVER(lbl, expr)
`endif

`endif

>>> sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// types and constants of the text console cell writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 32;
	localparam int TAB_STOP_DEF = 8;

	localparam int CELL_W = 16;

	localparam logic [7:0] CH_NL         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_BS         = 8'h08;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_LAST_PRINT = 8'h7F;

	localparam logic [3:0] RESET_FG = 4'd7;
	localparam logic [3:0] RESET_BG = 4'd0;

	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [5:0] ROWS_RESET = 6'd25;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef enum logic {
		REG_COLS = 1'b0,
		REG_ROWS = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_INIT_DRAIN,
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic walk;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic need_walk;
		logic walk_last;
	} stat_t;

	function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
			input logic [3:0] fg, input logic [3:0] bg);
		return {ch, fg, bg};
	endfunction

endpackage

`default_nettype wire

>>> sv/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// character cell text console: put, clear and read requests on a cell grid
// ----------------------------------------------------------------------------
// put (no scroll), read: done registered from ST_EXEC, one request at a time
// scroll and clear: a walk over every grid cell of the store through its single
//   write port, in states ST_EXEC, ST_WALK and ST_DRAIN
// reset: store cleared by the same walk, busy high through ST_INIT and
//   ST_INIT_DRAIN; results are never held off by the receiver
`default_nettype none

module text_console_cell_writer import tcw_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  char_code,
	input  wire logic [3:0]  text_fg,
	input  wire logic [3:0]  text_bg,
	input  wire logic [4:0]  read_row,
	input  wire logic [6:0]  read_col,
	output logic             done,
	output logic      [6:0]  cur_col,
	output logic      [4:0]  cur_row,
	output logic      [7:0]  cell_char,
	output logic      [3:0]  cell_fg,
	output logic      [3:0]  cell_bg
);

	logic [7:0] cols_in_use;
	logic [5:0] rows_in_use;
	cmd_t       cmd;
	stat_t      stat;

	tcw_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cols_in_use (cols_in_use),
		.rows_in_use (rows_in_use)
	);

	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	tcw_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.TAB_STOP (TAB_STOP)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cols_in_use (cols_in_use),
		.rows_in_use (rows_in_use),
		.req_type    (req_type),
		.char_code   (char_code),
		.text_fg     (text_fg),
		.text_bg     (text_bg),
		.read_row    (read_row),
		.read_col    (read_col),
		.done        (done),
		.cur_col     (cur_col),
		.cur_row     (cur_row),
		.cell_char   (cell_char),
		.cell_fg     (cell_fg),
		.cell_bg     (cell_bg)
	);

endmodule

`default_nettype wire

>>> sv/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> sv/tcw_regs.sv
// ----------------------------------------------------------------------------
// tcw_regs
// apb register file holding the visible columns and rows
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_regs import tcw_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [7:0]  cols_in_use,
	output logic      [5:0]  rows_in_use
);

	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_in_use <= COLS_RESET;
			rows_in_use <= ROWS_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_COLS: cols_in_use <= pwdata[7:0];
				REG_ROWS: rows_in_use <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COLS: prdata = {24'd0, cols_in_use};
			REG_ROWS: prdata = {26'd0, rows_in_use};
			default:  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// request sequencer: accept, execute, store walk and result strobe
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcw_ctrl import tcw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	output cmd_t       cmd,
	input  wire stat_t stat
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_INIT_DRAIN;
				end
			end
			ST_INIT_DRAIN: begin
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_walk) begin
					state_d = ST_WALK;
				end else begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.load_result = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`TCW_ASSERT(a_result_frees_port, cmd.load_result |=> !busy)
	`TCW_ASSERT(a_request_goes_busy, start && !busy |=> busy && state_q == ST_EXEC)
	`TCW_NEVER(a_walk_not_idle, cmd.walk && (cmd.accept || cmd.exec))

endmodule

`default_nettype wire

>>> sv/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// cursor, cell store and walk pipeline of the console writer
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcw_datapath import tcw_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	output stat_t           stat,
	input  wire logic [7:0] cols_in_use,
	input  wire logic [5:0] rows_in_use,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] char_code,
	input  wire logic [3:0] text_fg,
	input  wire logic [3:0] text_bg,
	input  wire logic [4:0] read_row,
	input  wire logic [6:0] read_col,
	output logic            done,
	output logic      [6:0] cur_col,
	output logic      [4:0] cur_row,
	output logic      [7:0] cell_char,
	output logic      [3:0] cell_fg,
	output logic      [3:0] cell_bg
);

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int XW    = $clog2(MAX_COLS + TAB_STOP);
	localparam int YW    = $clog2(MAX_ROWS + 1);
	localparam int LW    = $clog2(MAX_COLS + 1);
	localparam int AW    = RW + CW;
	localparam int DEPTH = MAX_ROWS * (2 ** CW);

	// configuration, saturated
	logic [LW-1:0] cols_c;
	logic [YW-1:0] rows_c;

	always_comb begin
		if (cols_in_use == '0) begin
			cols_c = LW'(1);
		end else if (int'(cols_in_use) > MAX_COLS) begin
			cols_c = LW'(MAX_COLS);
		end else begin
			cols_c = LW'(cols_in_use);
		end
		if (rows_in_use == '0) begin
			rows_c = YW'(1);
		end else if (int'(rows_in_use) > MAX_ROWS) begin
			rows_c = YW'(MAX_ROWS);
		end else begin
			rows_c = YW'(rows_in_use);
		end
	end

	// request and cursor registers
	logic [1:0]        req_q;
	logic [7:0]        ch_q;
	logic [3:0]        fg_q;
	logic [3:0]        bg_q;
	logic              rd_ok_q;
	logic [XW-1:0]     cur_x_q;
	logic [YW-1:0]     cur_y_q;
	logic [CELL_W-1:0] blank_q;
	logic [YW-1:0]     shift_q;
	logic [YW-1:0]     copy_rows_q;

	// walk counters and write stage
	logic [RW-1:0]     wk_row_q;
	logic [CW-1:0]     wk_col_q;
	logic              wen_s1;
	logic [RW-1:0]     wrow_s1;
	logic [CW-1:0]     wcol_s1;
	logic              copy_s1;

	// ram
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] rd_data;

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// tab stop table
	logic [XW-1:0] tab_tbl [MAX_COLS];

	for (genvar g = 0; g < MAX_COLS; g++) begin : g_tab
		assign tab_tbl[g] = XW'(g + TAB_STOP - (g % TAB_STOP));
	end

	// put request
	logic [XW-1:0]     x1, x2;
	logic [YW-1:0]     y1, y2, y3, shift_d;
	logic              put_wen;
	logic [CW-1:0]     put_wcol;
	logic [CELL_W-1:0] put_wdata;
	logic              scroll;
	logic              is_put;

	assign is_put = (req_q == REQ_PUT);

	always_comb begin
		x1        = cur_x_q;
		y1        = cur_y_q;
		put_wen   = 1'b0;
		put_wcol  = CW'(cur_x_q);
		put_wdata = make_cell(ch_q, fg_q, bg_q);
		case (ch_q)
			CH_NL: begin
				x1 = '0;
				y1 = cur_y_q + YW'(1);
			end
			CH_CR: begin
				x1 = '0;
			end
			CH_TAB: begin
				x1 = tab_tbl[CW'(cur_x_q)];
			end
			CH_BS: begin
				if (cur_x_q != '0) begin
					x1        = cur_x_q - XW'(1);
					put_wen   = 1'b1;
					put_wcol  = CW'(cur_x_q - XW'(1));
					put_wdata = {CH_SPACE, rd_data[7:0]};
				end
			end
			default: begin
				if (ch_q >= CH_SPACE && ch_q <= CH_LAST_PRINT && cur_x_q < cols_c) begin
					x1      = cur_x_q + XW'(1);
					put_wen = 1'b1;
				end
			end
		endcase
		if (x1 >= cols_c) begin
			x2 = '0;
			y2 = y1 + YW'(1);
		end else begin
			x2 = x1;
			y2 = y1;
		end
		scroll  = (y2 >= rows_c);
		shift_d = y2 - rows_c + YW'(1);
		y3      = scroll ? (rows_c - YW'(1)) : y2;
	end

	assign stat.need_walk = (req_q == REQ_CLEAR) || (is_put && scroll);
	assign stat.walk_last = (wk_row_q == RW'(MAX_ROWS - 1)) && (wk_col_q == CW'(MAX_COLS - 1));

	// walk copy source
	logic          wk_copy;
	logic [RW-1:0] wk_src_row;

	assign wk_copy    = (YW'(wk_row_q) < copy_rows_q);
	assign wk_src_row = wk_copy ? RW'(YW'(wk_row_q) + shift_q) : wk_row_q;

	// ram address and data selection
	logic [RW-1:0] acc_row;
	logic [CW-1:0] acc_col;

	always_comb begin
		if (req_type == REQ_READ) begin
			acc_row = RW'(read_row);
			acc_col = CW'(read_col);
		end else begin
			acc_row = RW'(cur_y_q);
			acc_col = CW'(cur_x_q - XW'(1));
		end
		ram_raddr = cmd.walk ? {wk_src_row, wk_col_q} : {acc_row, acc_col};
		if (wen_s1) begin
			ram_we    = 1'b1;
			ram_waddr = {wrow_s1, wcol_s1};
			ram_wdata = copy_s1 ? rd_data : blank_q;
		end else begin
			ram_we    = cmd.exec && is_put && put_wen;
			ram_waddr = {RW'(cur_y_q), put_wcol};
			ram_wdata = put_wdata;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			blank_q     <= make_cell(CH_SPACE, RESET_FG, RESET_BG);
			copy_rows_q <= '0;
			wk_row_q    <= '0;
			wk_col_q    <= '0;
			wen_s1      <= 1'b0;
			done        <= 1'b0;
		end else begin
			wen_s1 <= cmd.walk;
			done   <= cmd.load_result;
			if (cmd.exec) begin
				case (req_q)
					REQ_PUT: begin
						cur_x_q     <= x2;
						cur_y_q     <= y3;
						blank_q     <= make_cell(CH_SPACE, fg_q, bg_q);
						copy_rows_q <= YW'(MAX_ROWS) - shift_d;
					end
					REQ_CLEAR: begin
						cur_x_q     <= '0;
						cur_y_q     <= '0;
						blank_q     <= make_cell(CH_SPACE, fg_q, bg_q);
						copy_rows_q <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.walk) begin
				if (stat.walk_last) begin
					wk_row_q <= '0;
					wk_col_q <= '0;
				end else if (wk_col_q == CW'(MAX_COLS - 1)) begin
					wk_col_q <= '0;
					wk_row_q <= wk_row_q + RW'(1);
				end else begin
					wk_col_q <= wk_col_q + CW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q   <= req_type;
			ch_q    <= char_code;
			fg_q    <= text_fg;
			bg_q    <= text_bg;
			rd_ok_q <= (int'(read_row) < MAX_ROWS) && (int'(read_col) < MAX_COLS);
		end
		if (cmd.exec && is_put && scroll) begin
			shift_q <= shift_d;
		end
		wrow_s1 <= wk_row_q;
		wcol_s1 <= wk_col_q;
		copy_s1 <= wk_copy;
		if (cmd.load_result) begin
			cur_col <= (cmd.exec && is_put) ? 7'(x2) : 7'(cur_x_q);
			cur_row <= (cmd.exec && is_put) ? 5'(y3) : 5'(cur_y_q);
			if (cmd.exec && req_q == REQ_READ && rd_ok_q) begin
				{cell_char, cell_fg, cell_bg} <= rd_data;
			end else begin
				{cell_char, cell_fg, cell_bg} <= '0;
			end
		end
	end

	`TCW_NEVER(a_write_clash, wen_s1 && cmd.exec)
	`TCW_ASSERT(a_put_row_in_range, cmd.exec && is_put |=> cur_y_q < $past(rows_c))
	`TCW_ASSERT(a_put_col_in_range, cmd.exec && is_put |=> cur_x_q < $past(cols_c))

endmodule

`default_nettype wire
